// ===== src/fwop_pkg.sv =====
// Shared types, codes and constants of the frame FIFO with overflow policy.
`default_nettype none
package fwop_pkg;

    // Default sizes of the frame store and the saturating counters.
    localparam int DEPTH_DEFAULT       = 16;
    localparam int FRAME_WIDTH_DEFAULT = 64;
    localparam int COUNT_WIDTH_DEFAULT = 32;

    // Configuration register fields and the APB address and data widths.
    localparam int POLICY_WIDTH = 2;
    localparam int CAP_WIDTH    = 5;
    localparam int PADDR_WIDTH  = 3;
    localparam int PDATA_WIDTH  = 32;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    // Register indexes, taken from the word address.
    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    typedef enum logic [POLICY_WIDTH-1:0] {
        POLICY_LOSSLESS    = 2'd0,
        POLICY_DROP_OLDEST = 2'd1,
        POLICY_LATEST      = 2'd2
    } policy_t;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POLL  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_PUSH_OK       = 3'd0,
        STATUS_BACKPRESSURE  = 3'd1,
        STATUS_POLL_FRAME    = 3'd2,
        STATUS_POLL_EMPTY    = 3'd3,
        STATUS_CLEARED       = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_state_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        policy_t                policy;
        logic [CAP_WIDTH-1:0]   capacity;
    } cfg_t;

endpackage
`default_nettype wire

// ===== src/fwop_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module fwop_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/fwop_cfg.sv =====
// APB register block holding the overflow policy and the capacity in use.
`default_nettype none
module fwop_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fwop_pkg::PADDR_WIDTH-1:0]   paddr,
    input  wire logic [fwop_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic      [fwop_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                                    pready,
    output fwop_pkg::cfg_t                          cfg
);
    fwop_pkg::policy_t                   policy_reg;
    logic [fwop_pkg::CAP_WIDTH-1:0]      capacity_reg;
    logic                                wr_en;
    logic                                reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg   <= fwop_pkg::POLICY_LOSSLESS;
            capacity_reg <= fwop_pkg::CAP_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                fwop_pkg::REG_POLICY: begin
                    policy_reg <= fwop_pkg::policy_t'(pwdata[fwop_pkg::POLICY_WIDTH-1:0]);
                end
                fwop_pkg::REG_CAPACITY: begin
                    capacity_reg <= pwdata[fwop_pkg::CAP_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            fwop_pkg::REG_POLICY: begin
                prdata = fwop_pkg::PDATA_WIDTH'(policy_reg);
            end
            default: begin
                prdata = fwop_pkg::PDATA_WIDTH'(capacity_reg);
            end
        endcase
    end

    assign cfg.policy   = policy_reg;
    assign cfg.capacity = capacity_reg;

endmodule
`default_nettype wire

// ===== src/fwop_core.sv =====
// Sequencer, pointers, fill level, counters and result register of the FIFO.
`default_nettype none
module fwop_core #(
    parameter  int DEPTH       = fwop_pkg::DEPTH_DEFAULT,
    parameter  int FRAME_WIDTH = fwop_pkg::FRAME_WIDTH_DEFAULT,
    parameter  int COUNT_WIDTH = fwop_pkg::COUNT_WIDTH_DEFAULT,
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FILL_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire fwop_pkg::cfg_t             cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 in_mode,
    input  wire logic [FRAME_WIDTH-1:0]     in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [2:0]                      out_status,
    output logic [FRAME_WIDTH-1:0]          out_frame,
    output logic [FILL_W-1:0]               out_occupancy,
    output logic [COUNT_WIDTH-1:0]          out_pushed,
    output logic [COUNT_WIDTH-1:0]          out_polled,
    output logic [COUNT_WIDTH-1:0]          out_dropped,
    output logic [COUNT_WIDTH-1:0]          out_rejected,
    output logic                            ram_re,
    output logic [PTR_W-1:0]                ram_raddr,
    input  wire logic [FRAME_WIDTH-1:0]     ram_rdata,
    output logic                            ram_we,
    output logic [PTR_W-1:0]                ram_waddr,
    output logic [FRAME_WIDTH-1:0]          ram_wdata
);
    localparam int CAP_W  = fwop_pkg::CAP_WIDTH;
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam logic [PTR_W-1:0]       LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    fwop_pkg::fsm_state_t state_reg, state_next;
    fwop_pkg::mode_t      mode_reg;
    logic [FRAME_WIDTH-1:0] data_reg;

    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [COUNT_WIDTH-1:0] pushed_reg, pushed_next;
    logic [COUNT_WIDTH-1:0] polled_reg, polled_next;
    logic [COUNT_WIDTH-1:0] dropped_reg, dropped_next;
    logic [COUNT_WIDTH-1:0] rejected_reg, rejected_next;

    logic                   out_valid_reg;
    fwop_pkg::status_t      status_reg, status_next;
    logic [FRAME_WIDTH-1:0] frame_reg, frame_next;
    logic [FILL_W-1:0]      occ_reg;
    logic [COUNT_WIDTH-1:0] o_pushed_reg, o_polled_reg, o_dropped_reg, o_rejected_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   exec_fire;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   full;
    logic [COUNT_WIDTH:0]   drop_sum;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    assign in_ready  = (state_reg == fwop_pkg::S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign exec_fire = (state_reg == fwop_pkg::S_EXEC) && out_free;

    // The head entry is read as the transaction is accepted.
    assign ram_re    = in_fire;
    assign ram_raddr = rd_ptr_reg;

    // A capacity of zero counts as one; any capacity above the depth counts as the depth.
    assign cap_ext = CMP_W'(cfg.capacity);
    assign eff_cap = (cfg.capacity == '0) ? CMP_W'(1) :
                     ((cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext);
    assign full    = (CMP_W'(fill_reg) >= eff_cap);

    assign drop_sum = {1'b0, dropped_reg} + (COUNT_WIDTH + 1)'(fill_reg);

    always_comb begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        pushed_next   = pushed_reg;
        polled_next   = polled_reg;
        dropped_next  = dropped_reg;
        rejected_next = rejected_reg;
        status_next   = fwop_pkg::STATUS_CLEARED;
        frame_next    = '0;
        ram_we        = 1'b0;
        ram_waddr     = wr_ptr_reg;
        ram_wdata     = data_reg;

        unique case (state_reg)
            fwop_pkg::S_IDLE: begin
                if (in_fire) begin
                    state_next = fwop_pkg::S_EXEC;
                end
            end
            fwop_pkg::S_EXEC: begin
                case (mode_reg)
                    fwop_pkg::MODE_PUSH: begin
                        status_next = fwop_pkg::STATUS_PUSH_OK;
                        case (cfg.policy)
                            fwop_pkg::POLICY_LOSSLESS: begin
                                if (full) begin
                                    rejected_next = sat_inc(rejected_reg);
                                    status_next   = fwop_pkg::STATUS_BACKPRESSURE;
                                end else begin
                                    ram_we      = exec_fire;
                                    wr_ptr_next = next_slot(wr_ptr_reg);
                                    fill_next   = fill_reg + 1'b1;
                                    pushed_next = sat_inc(pushed_reg);
                                end
                            end
                            fwop_pkg::POLICY_DROP_OLDEST: begin
                                ram_we      = exec_fire;
                                wr_ptr_next = next_slot(wr_ptr_reg);
                                pushed_next = sat_inc(pushed_reg);
                                if (full) begin
                                    // The head is dropped and the new frame takes its place.
                                    rd_ptr_next  = next_slot(rd_ptr_reg);
                                    dropped_next = sat_inc(dropped_reg);
                                end else begin
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                            default: begin
                                // Latest only, which also covers the unused policy code.
                                dropped_next = drop_sum[COUNT_WIDTH] ? COUNT_MAX :
                                               drop_sum[COUNT_WIDTH-1:0];
                                rd_ptr_next  = wr_ptr_reg;
                                ram_we       = exec_fire;
                                wr_ptr_next  = next_slot(wr_ptr_reg);
                                fill_next    = FILL_W'(1);
                                pushed_next  = sat_inc(pushed_reg);
                            end
                        endcase
                    end
                    fwop_pkg::MODE_POLL: begin
                        if (fill_reg == '0) begin
                            status_next = fwop_pkg::STATUS_POLL_EMPTY;
                        end else begin
                            status_next = fwop_pkg::STATUS_POLL_FRAME;
                            frame_next  = ram_rdata;
                            rd_ptr_next = next_slot(rd_ptr_reg);
                            fill_next   = fill_reg - 1'b1;
                            polled_next = sat_inc(polled_reg);
                        end
                    end
                    default: begin
                        // Clear, which also covers the unused mode code.
                        rd_ptr_next = '0;
                        wr_ptr_next = '0;
                        fill_next   = '0;
                        status_next = fwop_pkg::STATUS_CLEARED;
                    end
                endcase
                if (exec_fire) begin
                    state_next = fwop_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fwop_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fwop_pkg::S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            pushed_reg    <= '0;
            polled_reg    <= '0;
            dropped_reg   <= '0;
            rejected_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                fill_reg      <= fill_next;
                pushed_reg    <= pushed_next;
                polled_reg    <= polled_next;
                dropped_reg   <= dropped_next;
                rejected_reg  <= rejected_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            mode_reg <= fwop_pkg::mode_t'(in_mode);
            data_reg <= in_data;
        end
        if (exec_fire) begin
            status_reg     <= status_next;
            frame_reg      <= frame_next;
            occ_reg        <= fill_next;
            o_pushed_reg   <= pushed_next;
            o_polled_reg   <= polled_next;
            o_dropped_reg  <= dropped_next;
            o_rejected_reg <= rejected_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = status_reg;
    assign out_frame     = frame_reg;
    assign out_occupancy = occ_reg;
    assign out_pushed    = o_pushed_reg;
    assign out_polled    = o_polled_reg;
    assign out_dropped   = o_dropped_reg;
    assign out_rejected  = o_rejected_reg;

endmodule
`default_nettype wire

// ===== src/fifo_with_overflow_policy.sv =====
// Top level of the bounded frame FIFO with a selectable overflow policy.
// Each transaction on the s_ channel is one operation: s_tuser selects push,
// poll or clear, and s_tdata carries the frame for a push. Every operation
// gives exactly one result transaction on the m_ channel: m_tuser holds the
// status and m_tdata the polled frame, the occupancy after the operation and
// the four saturating counters (pushed, polled, dropped, rejected).
// The APB port sets the overflow policy (lossless, drop oldest, latest only)
// at byte address 0 and the capacity in use at byte address 4; write it only
// while no operation is in flight.
// In the accept cycle of an operation the frame store is read at the head
// pointer, and in the execute state that follows the pointers, fill level and
// counters are updated, a push is written to the store and the result is
// loaded into the output register. The store's registered read port sets
// this split, so no new operation is taken until the current one has been
// executed, and m_tvalid rises when the execute state completes.
// The output register lets a new operation be accepted while a result waits.
// When the receiver stalls, the next operation holds in its update cycle and
// s_tready stays low until the output register frees.
// Reset clears the pointers, fill level and counters and sets the policy to
// lossless with a capacity of 16; the store contents are not cleared.
`default_nettype none
module fifo_with_overflow_policy #(
    parameter  int DEPTH       = fwop_pkg::DEPTH_DEFAULT,
    parameter  int FRAME_WIDTH = fwop_pkg::FRAME_WIDTH_DEFAULT,
    parameter  int COUNT_WIDTH = fwop_pkg::COUNT_WIDTH_DEFAULT,
    localparam int FILL_W      = $clog2(DEPTH + 1),
    localparam int S_TDATA_W   = ((FRAME_WIDTH + 7) / 8) * 8,
    localparam int M_RAW_W     = FRAME_WIDTH + FILL_W + 4 * COUNT_WIDTH,
    localparam int M_TDATA_W   = ((M_RAW_W + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input channel.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: frame_data.
    input  wire logic [S_TDATA_W-1:0]               s_tdata,
    // s_tuser: mode.
    input  wire logic [1:0]                         s_tuser,
    // Result channel.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: frame_out, occupancy, pushed_count, polled_count,
    // dropped_count, rejected_count.
    output logic [M_TDATA_W-1:0]                    m_tdata,
    // m_tuser: status.
    output logic [2:0]                              m_tuser,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fwop_pkg::PADDR_WIDTH-1:0]   paddr,
    input  wire logic [fwop_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic      [fwop_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                                    pready
);
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fwop_pkg::cfg_t          cfg;
    logic                    ram_re;
    logic [PTR_W-1:0]        ram_raddr;
    logic [FRAME_WIDTH-1:0]  ram_rdata;
    logic                    ram_we;
    logic [PTR_W-1:0]        ram_waddr;
    logic [FRAME_WIDTH-1:0]  ram_wdata;

    logic [FRAME_WIDTH-1:0]  frame_out;
    logic [FILL_W-1:0]       occupancy;
    logic [COUNT_WIDTH-1:0]  pushed_count;
    logic [COUNT_WIDTH-1:0]  polled_count;
    logic [COUNT_WIDTH-1:0]  dropped_count;
    logic [COUNT_WIDTH-1:0]  rejected_count;

    fwop_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fwop_ram #(
        .WIDTH (FRAME_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fwop_core #(
        .DEPTH       (DEPTH),
        .FRAME_WIDTH (FRAME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_mode       (s_tuser),
        .in_data       (s_tdata[FRAME_WIDTH-1:0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (m_tuser),
        .out_frame     (frame_out),
        .out_occupancy (occupancy),
        .out_pushed    (pushed_count),
        .out_polled    (polled_count),
        .out_dropped   (dropped_count),
        .out_rejected  (rejected_count),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    // Fields are packed from the lowest bit up and padded to whole bytes.
    assign m_tdata = M_TDATA_W'({rejected_count, dropped_count, polled_count,
                                 pushed_count, occupancy, frame_out});

endmodule
`default_nettype wire

// ===== tb/sv/fifo_with_overflow_policy_tb.sv =====
// Self-checking testbench for the frame FIFO with overflow policy: directed, random and stall tests.
module fifo_with_overflow_policy_tb;

    // Widths of the streaming buses. m_tdata packs frame_out, occupancy and
    // the four counters from bit 0 up, padded with zeros to whole bytes.
    localparam int FRAME_W   = 64;
    localparam int OCC_W     = 5;
    localparam int CNT_W     = 32;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 200;
    localparam int STORE_N   = 16;

    localparam int OFF_OCC      = FRAME_W;
    localparam int OFF_PUSHED   = OFF_OCC + OCC_W;
    localparam int OFF_POLLED   = OFF_PUSHED + CNT_W;
    localparam int OFF_DROPPED  = OFF_POLLED + CNT_W;
    localparam int OFF_REJECTED = OFF_DROPPED + CNT_W;

    // Byte addresses of the two registers (register i sits at 4*i).
    localparam logic [fwop_pkg::PADDR_WIDTH-1:0] ADDR_POLICY   =
        {fwop_pkg::REG_POLICY, 2'b00};
    localparam logic [fwop_pkg::PADDR_WIDTH-1:0] ADDR_CAPACITY =
        {fwop_pkg::REG_CAPACITY, 2'b00};

    // Encodings outside the named sets: the block treats every mode code
    // other than push and poll as a clear, so this one acts as a clear, and
    // this policy acts as latest only.
    localparam logic [1:0] MODE_CLEAR_ALIAS   = 2'd3;
    localparam logic [1:0] POLICY_LATEST_ALIAS = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYCLES = 6;

    typedef struct {
        fwop_pkg::status_t  status;
        logic [FRAME_W-1:0] frame;
        logic [OCC_W-1:0]   occupancy;
        logic [CNT_W-1:0]   pushed;
        logic [CNT_W-1:0]   polled;
        logic [CNT_W-1:0]   dropped;
        logic [CNT_W-1:0]   rejected;
    } fifo_result_t;

    // Tracks the FIFO contents, pointers and counters, and holds the results
    // that accepted operations are still owed.
    class fifo_policy_scoreboard;
        logic [FRAME_W-1:0] frames [STORE_N];
        int unsigned        head;
        int unsigned        tail;
        int unsigned        fill;
        logic [CNT_W-1:0]   pushed;
        logic [CNT_W-1:0]   polled;
        logic [CNT_W-1:0]   dropped;
        logic [CNT_W-1:0]   rejected;
        logic [1:0]         policy;
        logic [4:0]         capacity;
        fifo_result_t       owed_q [$];
        int                 errors;

        function new();
            head     = 0;
            tail     = 0;
            fill     = 0;
            pushed   = '0;
            polled   = '0;
            dropped  = '0;
            rejected = '0;
            policy   = fwop_pkg::POLICY_LOSSLESS;
            capacity = fwop_pkg::CAP_RESET;
            errors   = 0;
        endfunction

        function void write_register(logic [fwop_pkg::PADDR_WIDTH-1:0] addr,
                                     logic [31:0] value);
            if (addr == ADDR_POLICY)
                policy = value[1:0];
            else if (addr == ADDR_CAPACITY)
                capacity = value[4:0];
        endfunction

        function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] count, int unsigned amount);
            longint unsigned sum;
            sum = longint'(count) + amount;
            return (sum > {CNT_W{1'b1}}) ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
        endfunction

        function void append(logic [FRAME_W-1:0] data);
            frames[tail] = data;
            tail = (tail + 1) % STORE_N;
            fill++;
            pushed = sat_add(pushed, 1);
        endfunction

        // Applies one accepted operation and queues the result it must give.
        function void note_operation(logic [1:0] mode, logic [FRAME_W-1:0] data);
            fifo_result_t r;
            int unsigned  limit;
            r.frame = '0;
            limit = (capacity == 0) ? 1 : ((capacity > STORE_N) ? STORE_N : capacity);
            if (mode[1]) begin
                head = 0;
                tail = 0;
                fill = 0;
                r.status = fwop_pkg::STATUS_CLEARED;
            end else if (mode == fwop_pkg::MODE_POLL) begin
                if (fill == 0) begin
                    r.status = fwop_pkg::STATUS_POLL_EMPTY;
                end else begin
                    r.frame = frames[head];
                    head = (head + 1) % STORE_N;
                    fill--;
                    polled = sat_add(polled, 1);
                    r.status = fwop_pkg::STATUS_POLL_FRAME;
                end
            end else if (policy[1]) begin
                // Latest only: everything held is discarded and counted.
                dropped = sat_add(dropped, fill);
                fill = 0;
                head = tail;
                append(data);
                r.status = fwop_pkg::STATUS_PUSH_OK;
            end else if (fill >= limit) begin
                if (policy == fwop_pkg::POLICY_LOSSLESS) begin
                    rejected = sat_add(rejected, 1);
                    r.status = fwop_pkg::STATUS_BACKPRESSURE;
                end else begin
                    head = (head + 1) % STORE_N;
                    fill--;
                    dropped = sat_add(dropped, 1);
                    append(data);
                    r.status = fwop_pkg::STATUS_PUSH_OK;
                end
            end else begin
                append(data);
                r.status = fwop_pkg::STATUS_PUSH_OK;
            end
            r.occupancy = fill[OCC_W-1:0];
            r.pushed    = pushed;
            r.polled    = polled;
            r.dropped   = dropped;
            r.rejected  = rejected;
            owed_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [FRAME_W-1:0] want,
                                    logic [FRAME_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] status, logic [M_DATA_W-1:0] tdata);
            fifo_result_t r;
            if (owed_q.size() == 0) begin
                $error("result transaction with none outstanding: status %0d", status);
                errors++;
                return;
            end
            r = owed_q[0];
            owed_q.delete(0);
            compare_field("status", 64'(r.status), 64'(status));
            compare_field("frame_out", r.frame, tdata[FRAME_W-1:0]);
            compare_field("occupancy", 64'(r.occupancy), 64'(tdata[OFF_OCC +: OCC_W]));
            compare_field("pushed_count", 64'(r.pushed), 64'(tdata[OFF_PUSHED +: CNT_W]));
            compare_field("polled_count", 64'(r.polled), 64'(tdata[OFF_POLLED +: CNT_W]));
            compare_field("dropped_count", 64'(r.dropped), 64'(tdata[OFF_DROPPED +: CNT_W]));
            compare_field("rejected_count", 64'(r.rejected),
                          64'(tdata[OFF_REJECTED +: CNT_W]));
            compare_field("m_tdata padding", 64'd0, 64'(tdata[M_DATA_W-1:OFF_REJECTED+CNT_W]));
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [S_DATA_W-1:0]                 s_tdata;     // frame_data
    logic [1:0]                          s_tuser;     // mode
    logic                                m_tvalid;
    logic                                m_tready;
    logic [M_DATA_W-1:0]                 m_tdata;     // frame_out, occupancy, pushed_count,
                                                      // polled_count, dropped_count,
                                                      // rejected_count
    logic [2:0]                          m_tuser;     // status
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [fwop_pkg::PADDR_WIDTH-1:0]    paddr;
    logic [fwop_pkg::PDATA_WIDTH-1:0]    pwdata;
    logic [fwop_pkg::PDATA_WIDTH-1:0]    prdata;
    logic                                pready;

    fifo_policy_scoreboard sb = new();

    // Controls shared between the sender and the receiver processes.
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          rx_hold_request = 1'b0;
    int unsigned rx_hold_cycles = 0;
    int unsigned cycle_count = 0;

    always #2 aclk = ~aclk;

    fifo_with_overflow_policy dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Monitor for both channels. The result is checked before the input is
    // noted, so a transaction accepted at this edge can never be matched
    // against a result that was already on the bus.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_operation(s_tuser, s_tdata);
        end
    end

    // Receiver. It stalls in random bursts while idling is enabled, and on
    // request holds m_tready low for a long, counted stretch so that the
    // output register fills and the block stops taking operations.
    initial begin
        forever begin
            if (rx_hold_request) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_request = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Two-phase register write; the register takes the value at the edge
    // of the access cycle, and the predictor follows at the same time.
    // The bus is then left idle before the task returns.
    task automatic apb_write(logic [fwop_pkg::PADDR_WIDTH-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_register(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one operation and returns at the edge where it is accepted.
    // s_tvalid stays high so a following call can present the next
    // transaction without a bubble.
    task automatic send_op(logic [1:0] mode, logic [S_DATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random sender gap, taken with a chance of one in six while idling is enabled.
    task automatic maybe_idle();
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every owed result has come back, then
    // lets the pipeline settle. The first edge lets the monitor note the
    // transaction accepted at the current one.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [1:0] policy, logic [4:0] capacity);
        wait_drained();
        apb_write(ADDR_POLICY, 32'(policy));
        apb_write(ADDR_CAPACITY, 32'(capacity));
    endtask

    // Random frame with occasional all-zero and all-one payloads, so every
    // data bit sees both values and the extremes recur.
    function automatic logic [S_DATA_W-1:0] random_frame();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A run of random operations. push_weight is the percentage of pushes;
    // a few percent are clears (both encodings) and the rest are polls.
    task automatic random_ops(int count, int push_weight);
        int          pick;
        logic [1:0]  mode;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_weight)
                mode = fwop_pkg::MODE_PUSH;
            else if (pick < 96)
                mode = fwop_pkg::MODE_POLL;
            else
                mode = ($urandom_range(0, 1) != 0) ? fwop_pkg::MODE_CLEAR : MODE_CLEAR_ALIAS;
            maybe_idle();
            send_op(mode, random_frame());
        end
    endtask

    // Main sequence: reset, directed cases, then random phases with
    // different policies and capacities; the final phase runs without idling.
    initial begin
        logic [1:0]  phase_policy [8];
        logic [4:0]  phase_cap    [8];
        int          phase_push   [8];

        phase_policy = '{fwop_pkg::POLICY_LOSSLESS, fwop_pkg::POLICY_DROP_OLDEST,
                         fwop_pkg::POLICY_LATEST, fwop_pkg::POLICY_LOSSLESS,
                         fwop_pkg::POLICY_DROP_OLDEST, POLICY_LATEST_ALIAS,
                         fwop_pkg::POLICY_DROP_OLDEST, fwop_pkg::POLICY_LOSSLESS};
        phase_cap    = '{5'd16, 5'd3, 5'd7, 5'd31, 5'd0, 5'd12, 5'd16, 5'd4};
        phase_push   = '{70, 60, 55, 75, 60, 55, 65, 55};

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= fwop_pkg::MODE_PUSH;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // Directed part at the reset configuration: poll of an empty store,
        // payload extremes, and a clear through the aliased mode encoding.
        send_op(fwop_pkg::MODE_POLL, '0);
        send_op(fwop_pkg::MODE_PUSH, '0);
        send_op(fwop_pkg::MODE_PUSH, '1);
        send_op(fwop_pkg::MODE_PUSH, 64'h8000_0000_0000_0001);
        send_op(fwop_pkg::MODE_PUSH, 64'h5555_AAAA_5555_AAAA);
        send_op(fwop_pkg::MODE_POLL, 64'h1234);
        send_op(fwop_pkg::MODE_POLL, '1);
        send_op(MODE_CLEAR_ALIAS, '1);
        send_op(fwop_pkg::MODE_POLL, '0);

        // Lossless at capacity two: the third push is refused.
        set_config(fwop_pkg::POLICY_LOSSLESS, 5'd2);
        send_op(fwop_pkg::MODE_PUSH, 64'hDEAD_BEEF_0000_0001);
        send_op(fwop_pkg::MODE_PUSH, 64'hDEAD_BEEF_0000_0002);
        send_op(fwop_pkg::MODE_PUSH, 64'hDEAD_BEEF_0000_0003);

        // Capacity lowered below the fill: lossless still refuses.
        set_config(fwop_pkg::POLICY_LOSSLESS, 5'd1);
        send_op(fwop_pkg::MODE_PUSH, 64'hDEAD_BEEF_0000_0004);

        // Drop-oldest above the lowered capacity keeps the fill unchanged.
        set_config(fwop_pkg::POLICY_DROP_OLDEST, 5'd1);
        send_op(fwop_pkg::MODE_PUSH, 64'hDEAD_BEEF_0000_0005);
        send_op(fwop_pkg::MODE_POLL, '0);
        send_op(fwop_pkg::MODE_PUSH, 64'hDEAD_BEEF_0000_0006);

        // Latest only counts everything held as dropped; the unnamed policy
        // encoding behaves the same way.
        set_config(fwop_pkg::POLICY_LATEST, 5'd16);
        send_op(fwop_pkg::MODE_PUSH, 64'hCAFE_0000_0000_0001);
        send_op(fwop_pkg::MODE_PUSH, 64'hCAFE_0000_0000_0002);
        set_config(POLICY_LATEST_ALIAS, 5'd16);
        send_op(fwop_pkg::MODE_PUSH, 64'hCAFE_0000_0000_0003);
        send_op(fwop_pkg::MODE_CLEAR, '0);

        // A capacity of zero acts as one.
        set_config(fwop_pkg::POLICY_DROP_OLDEST, 5'd0);
        send_op(fwop_pkg::MODE_PUSH, 64'h0F0F_0F0F_0F0F_0F0F);
        send_op(fwop_pkg::MODE_PUSH, 64'hF0F0_F0F0_F0F0_F0F0);
        send_op(fwop_pkg::MODE_POLL, '0);

        for (int p = 0; p < 8; p++) begin
            set_config(phase_policy[p], phase_cap[p]);
            if (p == 0) begin
                // Long receiver stall while the sender keeps offering, so the
                // output register fills and s_tready drops.
                rx_hold_cycles = 100;
                rx_hold_request = 1'b1;
                for (int i = 0; i < 30; i++)
                    send_op(($urandom_range(0, 3) != 0) ? fwop_pkg::MODE_PUSH :
                                                          fwop_pkg::MODE_POLL,
                            random_frame());
            end
            if (p == 7) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            random_ops(120, phase_push[p]);
            if (p == 1)
                wait_drained();
            random_ops(120, phase_push[p]);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (sb.owed_q.size() != 0)
                $error("%0d result transactions never arrived", sb.owed_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
